### rtl/lpr_pkg.sv
// Shared constants and types of the luminance palette retint unit.
package lpr_pkg;

    localparam int LPR_MAX_ENTRIES = 64;
    localparam int LPR_ADDR_W      = $clog2(LPR_MAX_ENTRIES);
    localparam int LPR_CNT_W       = $clog2(LPR_MAX_ENTRIES + 1);

    localparam int LPR_CHAN_W      = 8;
    localparam int LPR_PIX_W       = 3 * LPR_CHAN_W;
    localparam int LPR_STORE_W     = LPR_PIX_W + LPR_CHAN_W;

    localparam int LPR_SUM_W       = 18;
    localparam int LPR_RECIP       = 4194;
    localparam int LPR_RECIP_W     = 13;
    localparam int LPR_RECIP_SH    = 22;
    localparam int LPR_LUMA_DIV    = 1000;

    localparam int LPR_DIV_W       = 16;
    localparam int LPR_DIV_CNT_W   = $clog2(LPR_DIV_W);

    localparam int LPR_CFG_IDX_W   = 2;
    localparam logic [LPR_CFG_IDX_W-1:0] LPR_REG_TINT_RED   = 2'd0;
    localparam logic [LPR_CFG_IDX_W-1:0] LPR_REG_TINT_GREEN = 2'd1;
    localparam logic [LPR_CFG_IDX_W-1:0] LPR_REG_TINT_BLUE  = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [LPR_DIV_W-1:0]  dividend;
        logic [LPR_CHAN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [LPR_DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

### rtl/lpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lpr_div.sv
// Restoring divider, one quotient bit per cycle, shared by every entry of an emit pass unless the part is dark.
module lpr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpr_pkg::t_div_req i_req,
    output lpr_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [lpr_pkg::LPR_DIV_CNT_W-1:0]   r_cnt;
    logic [lpr_pkg::LPR_CHAN_W-1:0]      r_rem;
    logic [lpr_pkg::LPR_DIV_W-1:0]       r_quot;
    logic [lpr_pkg::LPR_CHAN_W-1:0]      r_divisor;

    logic [lpr_pkg::LPR_CHAN_W:0]        shifted;
    logic [lpr_pkg::LPR_CHAN_W:0]        diff;
    logic                                fits;
    logic [lpr_pkg::LPR_CHAN_W-1:0]      n_rem;
    logic [lpr_pkg::LPR_DIV_W-1:0]       n_quot;

    // The partial remainder stays below the divisor, so it fits one channel width.
    always_comb begin
        shifted = {r_rem, r_quot[lpr_pkg::LPR_DIV_W-1]};
        diff    = shifted - {1'b0, r_divisor};
        fits    = shifted >= {1'b0, r_divisor};
        n_rem   = fits ? diff[lpr_pkg::LPR_CHAN_W-1:0] : shifted[lpr_pkg::LPR_CHAN_W-1:0];
        n_quot  = {r_quot[lpr_pkg::LPR_DIV_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_rem     <= '0;
                r_quot    <= i_req.dividend;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == lpr_pkg::LPR_DIV_CNT_W'(lpr_pkg::LPR_DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### rtl/luminance_palette_retint_unit.sv
// Top level of the luminance palette retint unit: load sequencer, luma, emit pass.
//
// The unit collects the colours of one palette part, one request per entry, and
// when the request marked with tlast arrives it sends every stored entry back out
// in load order, recoloured towards the tint colour while keeping each entry's
// brightness relative to the brightest entry of the part; a part whose brightest
// entry has zero luma comes back unchanged. Up to 64 entries are kept per part and
// further entries are dropped, though a dropped entry that carries tlast still
// starts the emit pass. Loading an entry takes the request cycle and then the sum,
// reciprocal and luma states, which form the luma (299R+587G+114B)/1000 by a sum of
// constant products, a reciprocal multiply and a single correction step. During the
// emit pass each entry passes one RAM read, a bit-serial divider that forms the
// brightness ratio and one shared 8x8 multiplier that scales the three channels in
// turn, plus any wait for the downstream side; a dark part skips the divider and the
// multiplier. The input side is not ready while an entry is being loaded or while a
// part is being emitted. Tint registers reset to white; the user writes them through
// a simple index/data port only while the unit is idle, which the unit does not enforce.
module luminance_palette_retint_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // Input entries.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // entry_red[7:0], entry_green[15:8], entry_blue[23:16]
    input  logic        s_axis_tlast,   // last_entry
    // Retinted entries.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic        m_axis_tlast    // out_last
);

    localparam int CW = lpr_pkg::LPR_CHAN_W;
    localparam int AW = lpr_pkg::LPR_ADDR_W;
    localparam int NW = lpr_pkg::LPR_CNT_W;
    localparam int SW = lpr_pkg::LPR_SUM_W;
    localparam int PW = SW + lpr_pkg::LPR_RECIP_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SUM     = 4'd1;
    localparam logic [3:0] ST_RECIP   = 4'd2;
    localparam logic [3:0] ST_LUMA    = 4'd3;
    localparam logic [3:0] ST_READ    = 4'd4;
    localparam logic [3:0] ST_SETUP   = 4'd5;
    localparam logic [3:0] ST_DIVIDE  = 4'd6;
    localparam logic [3:0] ST_MULT    = 4'd7;
    localparam logic [3:0] ST_SCALE   = 4'd8;
    localparam logic [3:0] ST_OUT     = 4'd9;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [3:0]      r_state;
    logic [CW-1:0]   r_tint_r;
    logic [CW-1:0]   r_tint_g;
    logic [CW-1:0]   r_tint_b;
    logic [NW-1:0]   r_count;
    logic [CW-1:0]   r_bright;
    logic [AW-1:0]   r_idx;
    logic [1:0]      r_ch;

    // Entry being loaded and its luma arithmetic.
    logic [CW-1:0]   r_in_r;
    logic [CW-1:0]   r_in_g;
    logic [CW-1:0]   r_in_b;
    logic            r_in_last;
    logic [SW-1:0]   r_sum;
    logic [PW-1:0]   r_lprod;

    // Emit pass arithmetic and the output register.
    logic [CW-1:0]   r_ratio;
    logic [2*CW-1:0] r_mprod;
    logic [CW-1:0]   r_out_r;
    logic [CW-1:0]   r_out_g;
    logic [CW-1:0]   r_out_b;
    logic            r_out_last;

    logic            in_fire;
    logic            out_fire;
    logic            store_full;

    logic [SW-1:0]   luma_sum;
    logic [CW-1:0]   luma_est;
    logic [SW-1:0]   luma_rem;
    logic [CW-1:0]   luma;

    logic            ram_we;
    logic [lpr_pkg::LPR_STORE_W-1:0] ram_wdata;
    logic [lpr_pkg::LPR_STORE_W-1:0] ram_rdata;
    logic [CW-1:0]   rd_r;
    logic [CW-1:0]   rd_g;
    logic [CW-1:0]   rd_b;
    logic [CW-1:0]   rd_luma;
    logic            rd_is_last;

    lpr_pkg::t_div_req div_req;
    lpr_pkg::t_div_rsp div_rsp;
    logic [CW-1:0]   div_ratio;

    logic [CW-1:0]   tint_sel;
    logic [24:0]     sc_prod;
    logic [CW:0]     sc_est;
    logic [16:0]     sc_rem;
    logic [CW:0]     sc_quot;
    logic [CW-1:0]   sc_chan;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_fire   = m_axis_tvalid && m_axis_tready;
    assign store_full = r_count >= NW'(lpr_pkg::LPR_MAX_ENTRIES);

    // Weighted channel sum; the constant products reduce to shift-and-add.
    assign luma_sum = SW'(r_in_r) * SW'(299) + SW'(r_in_g) * SW'(587)
                    + SW'(r_in_b) * SW'(114);

    // Divide by 1000 through a reciprocal that can fall short by one at most.
    always_comb begin
        luma_est = r_lprod[lpr_pkg::LPR_RECIP_SH +: CW];
        luma_rem = r_sum - SW'(luma_est) * SW'(lpr_pkg::LPR_LUMA_DIV);
        luma     = (luma_rem >= SW'(lpr_pkg::LPR_LUMA_DIV)) ? luma_est + 1'b1 : luma_est;
    end

    assign ram_we    = (r_state == ST_LUMA);
    assign ram_wdata = {luma, r_in_b, r_in_g, r_in_r};

    lpr_ram #(
        .WIDTH (lpr_pkg::LPR_STORE_W),
        .DEPTH (lpr_pkg::LPR_MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_r       = ram_rdata[0 +: CW];
    assign rd_g       = ram_rdata[CW +: CW];
    assign rd_b       = ram_rdata[2*CW +: CW];
    assign rd_luma    = ram_rdata[3*CW +: CW];
    assign rd_is_last = (NW'(r_idx) + 1'b1) == r_count;

    // Ratio dividend is luma * 255, divisor is the brightest luma of the part.
    assign div_req.start    = (r_state == ST_SETUP) && (r_bright != '0);
    assign div_req.dividend = {rd_luma, {CW{1'b0}}} - {{CW{1'b0}}, rd_luma};
    assign div_req.divisor  = r_bright;

    lpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // An entry never outshines the brightest one, so the ratio stays within 255.
    assign div_ratio = (div_rsp.quot > lpr_pkg::LPR_DIV_W'(255)) ? CW'(255)
                                                                  : div_rsp.quot[CW-1:0];

    always_comb begin
        unique case (r_ch)
            CH_RED:   tint_sel = r_tint_r;
            CH_GREEN: tint_sel = r_tint_g;
            default:  tint_sel = r_tint_b;
        endcase
    end

    // Divide the channel product by 255: multiply by 257/65536, then one correction.
    always_comb begin
        sc_prod = {9'b0, r_mprod} + {1'b0, r_mprod, 8'b0};
        sc_est  = sc_prod[16 +: CW+1];
        sc_rem  = {1'b0, r_mprod} - ({sc_est, 8'b0} - {8'b0, sc_est});
        sc_quot = (sc_rem >= 17'd255) ? sc_est + 1'b1 : sc_est;
        sc_chan = (sc_quot > 9'd255) ? CW'(255) : sc_quot[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_r <= 8'hFF;
            r_tint_g <= 8'hFF;
            r_tint_b <= 8'hFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpr_pkg::LPR_REG_TINT_RED:   r_tint_r <= i_cfg_data;
                lpr_pkg::LPR_REG_TINT_GREEN: r_tint_g <= i_cfg_data;
                lpr_pkg::LPR_REG_TINT_BLUE:  r_tint_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_bright <= '0;
            r_idx    <= '0;
            r_ch     <= CH_RED;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_in_r    <= s_axis_tdata[0 +: CW];
                        r_in_g    <= s_axis_tdata[CW +: CW];
                        r_in_b    <= s_axis_tdata[2*CW +: CW];
                        r_in_last <= s_axis_tlast;
                        r_idx     <= '0;
                        // A full store drops the entry but still honors its last flag.
                        if (!store_full) begin
                            r_state <= ST_SUM;
                        end else if (s_axis_tlast) begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_SUM: begin
                    r_sum   <= luma_sum;
                    r_state <= ST_RECIP;
                end
                ST_RECIP: begin
                    r_lprod <= PW'(r_sum) * PW'(lpr_pkg::LPR_RECIP);
                    r_state <= ST_LUMA;
                end
                ST_LUMA: begin
                    r_count <= r_count + 1'b1;
                    if (luma > r_bright) begin
                        r_bright <= luma;
                    end
                    r_state <= r_in_last ? ST_READ : ST_IDLE;
                end
                ST_READ: begin
                    r_state <= ST_SETUP;
                end
                ST_SETUP: begin
                    r_out_last <= rd_is_last;
                    if (r_bright == '0) begin
                        r_out_r <= rd_r;
                        r_out_g <= rd_g;
                        r_out_b <= rd_b;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (div_rsp.done) begin
                        r_ratio <= div_ratio;
                        r_ch    <= CH_RED;
                        r_state <= ST_MULT;
                    end
                end
                ST_MULT: begin
                    r_mprod <= (2*CW)'(tint_sel) * (2*CW)'(r_ratio);
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    unique case (r_ch)
                        CH_RED:   r_out_r <= sc_chan;
                        CH_GREEN: r_out_g <= sc_chan;
                        default:  r_out_b <= sc_chan;
                    endcase
                    if (r_ch == CH_BLUE) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= ST_MULT;
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        if (r_out_last) begin
                            r_count  <= '0;
                            r_bright <= '0;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_READ;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {r_out_b, r_out_g, r_out_r};
    assign m_axis_tlast  = r_out_last;

endmodule

### rtl/lpr_checker.sv
// Port-level checks of the luminance palette retint unit and their binding.
module lpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // The unit never takes a new entry while a part is still being sent out.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while an output request is pending");

    // Taking the final entry of a part starts its emit pass, so the input side closes.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after the final entry of a part");

    // Once the downstream side takes the final entry of a part, the emit pass ends.
    a_part_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("output continues past the final entry of a part");

    // A stalled output request keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output request changed");

endmodule

bind luminance_palette_retint_unit lpr_checker u_lpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
